// ===== rtl/ordered_list_append_remove_defines.svh =====
// Assertion macros shared by the ordered list RTL
`ifndef ORDERED_LIST_APPEND_REMOVE_DEFINES_SVH
`define ORDERED_LIST_APPEND_REMOVE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define OLAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ordered list check failed");

// Next-cycle implication, checked outside reset
`define OLAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ordered list check failed");

`endif

// ===== rtl/olar_pkg.sv =====
// Types and codes shared by the ordered list cells and controller
package olar_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_APPEND = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_DUMP   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_APPEND = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  // Command broadcast to every cell
  typedef struct packed {
    cell_op_e          op;
    logic              first;
    logic [DataW-1:0]  value;
  } cmd_t;

endpackage

// ===== rtl/olar_cell.sv =====
// One list cell: holds one entry, shifts, appends and rotates with its neighbors
module olar_cell
  import olar_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [DataW-1:0] head_data_i,
  input  logic             head_mark_i,
  input  logic             prv_valid_i,
  input  logic             nxt_valid_i,
  input  logic [DataW-1:0] nxt_data_i,
  input  logic             nxt_mark_i,
  input  logic             hit_i,
  output logic             valid_o,
  output logic [DataW-1:0] data_o,
  output logic             mark_o,
  output logic             hit_o
);

  logic             valid_q, valid_d;
  logic [DataW-1:0] data_q, data_d;
  logic             mark_q, mark_d;
  logic             tail;
  logic             match;
  logic             eff_mark;

  assign tail     = valid_q & ~nxt_valid_i;
  // at the start of a dump the tail cell tags its entry as the last one
  assign eff_mark = cmd_i.first ? tail : mark_q;
  assign match    = valid_q & (data_q == cmd_i.value);

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign mark_o  = eff_mark;
  assign hit_o   = hit_i | match;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    mark_d  = eff_mark;
    case (cmd_i.op)
      OP_APPEND: begin
        if (!valid_q && prv_valid_i) begin
          valid_d = 1'b1;
          data_d  = cmd_i.value;
        end
      end
      OP_REMOVE: begin
        // close the gap behind the first match
        if (hit_i || match) begin
          valid_d = nxt_valid_i;
          data_d  = nxt_data_i;
        end
      end
      OP_ROTATE: begin
        if (valid_q) begin
          if (nxt_valid_i) begin
            data_d = nxt_data_i;
            mark_d = nxt_mark_i;
          end else begin
            data_d = head_data_i;
            mark_d = head_mark_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    mark_q <= mark_d;
  end

endmodule

// ===== rtl/olar_ctrl.sv =====
// Command decoder, dump sequencer and result register
module olar_ctrl
  import olar_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [ActionW-1:0] action_i,
  input  logic [DataW-1:0]   value_i,
  input  logic               head_valid_i,
  input  logic [DataW-1:0]   head_data_i,
  input  logic               head_last_i,
  input  logic               full_i,
  input  logic               found_i,
  output cmd_t               cmd_o,
  output logic               strobe_o,
  output logic [StatusW-1:0] status_o,
  output logic [DataW-1:0]   entry_o,
  output logic               last_o
);

  state_e           state_q, state_d;
  logic             accept;
  action_e          action;
  logic             strobe_q, strobe_d;
  status_e          status_q, status_d;
  logic [DataW-1:0] entry_q, entry_d;
  logic             last_q, last_d;

  assign busy   = (state_q == S_DUMP);
  assign accept = start & ~busy;
  assign action = action_e'(action_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (action == ACT_DUMP) && head_valid_i && !head_last_i) begin
          state_d = S_DUMP;
        end
      end
      S_DUMP: begin
        if (head_last_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // cell command: depends on registers and inputs only; of the row's replies it uses only the registered head valid bit
  always_comb begin
    cmd_o.op    = OP_HOLD;
    cmd_o.first = 1'b0;
    cmd_o.value = value_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_APPEND: cmd_o.op = OP_APPEND;
            ACT_REMOVE: cmd_o.op = OP_REMOVE;
            ACT_DUMP: begin
              if (head_valid_i) begin
                cmd_o.op    = OP_ROTATE;
                cmd_o.first = 1'b1;
              end
            end
            ACT_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        cmd_o.op = OP_ROTATE;
      end
      default: begin
      end
    endcase
  end

  // result word
  always_comb begin
    strobe_d = 1'b0;
    status_d = ST_DONE;
    entry_d  = '0;
    last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          strobe_d = 1'b1;
          unique case (action)
            ACT_APPEND: begin
              status_d = full_i ? ST_FULL : ST_DONE;
            end
            ACT_REMOVE: begin
              status_d = found_i ? ST_DONE : ST_NOTFOUND;
            end
            ACT_DUMP: begin
              if (head_valid_i) begin
                status_d = ST_ENTRY;
                entry_d  = head_data_i;
                last_d   = head_last_i;
              end else begin
                status_d = ST_EMPTY;
              end
            end
            ACT_NONE: begin
              status_d = ST_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        strobe_d = 1'b1;
        status_d = ST_ENTRY;
        entry_d  = head_data_i;
        last_d   = head_last_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    entry_q  <= entry_d;
    last_q   <= last_d;
  end

  assign strobe_o = strobe_q;
  assign status_o = status_q;
  assign entry_o  = entry_q;
  assign last_o   = last_q;

endmodule

// ===== rtl/ordered_list_append_remove.sv =====
// Ordered list top level: a row of list cells and the command controller
//
// Usage: raise start with action_i and value_i while busy is low; the word is
// taken at that clock edge. Append (0) places value_i behind the tail, remove
// (1) deletes the first equal entry from the head and closes the gap, dump (2)
// emits all entries from head to tail. Code 3 does nothing and reports done.
// Each result shows on status_o, entry_o and last_o for one cycle with
// strobe_o high; last_o marks the final result of a command.
// The first result is registered and appears in the cycle after the command
// is taken. Append, remove and the no-op finish with that result, so a new
// command may follow every cycle. A dump of N entries gives one entry per
// cycle as the row rotates once through its occupied cells; busy stays high
// while the entries after the first are emitted. A dump of an empty list
// gives one result with status empty.
// Reset clears every valid bit, so the list starts empty.
// The receiver cannot stall; results are never held back.
module ordered_list_append_remove
  import olar_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ActionW-1:0]  action_i,
  input  logic signed [31:0]  value_i,
  output logic                strobe_o,
  output logic [StatusW-1:0]  status_o,
  output logic signed [31:0]  entry_o,
  output logic                last_o
);

`include "ordered_list_append_remove_defines.svh"

  cmd_t                    cmd;
  logic [CAPACITY-1:0]     valid_w;
  logic [CAPACITY+1:0]     valid_x;
  logic [DataW-1:0]        data_x [CAPACITY+1];
  logic [CAPACITY:0]       mark_x;
  logic [CAPACITY:0]       hit_x;
  logic [DataW-1:0]        entry_w;

  // guard bits: cell 0 sees a valid left neighbor, the last cell an empty right one
  assign valid_x            = {1'b0, valid_w, 1'b1};
  assign data_x[CAPACITY]   = '0;
  assign mark_x[CAPACITY]   = 1'b0;
  assign hit_x[0]           = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    olar_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .head_data_i (data_x[0]),
      .head_mark_i (mark_x[0]),
      .prv_valid_i (valid_x[i]),
      .nxt_valid_i (valid_x[i+2]),
      .nxt_data_i  (data_x[i+1]),
      .nxt_mark_i  (mark_x[i+1]),
      .hit_i       (hit_x[i]),
      .valid_o     (valid_w[i]),
      .data_o      (data_x[i]),
      .mark_o      (mark_x[i]),
      .hit_o       (hit_x[i+1])
    );
  end

  olar_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .value_i      (value_i),
    .head_valid_i (valid_w[0]),
    .head_data_i  (data_x[0]),
    .head_last_i  (mark_x[0]),
    .full_i       (valid_w[CAPACITY-1]),
    .found_i      (hit_x[CAPACITY]),
    .cmd_o        (cmd),
    .strobe_o     (strobe_o),
    .status_o     (status_o),
    .entry_o      (entry_w),
    .last_o       (last_o)
  );

  assign entry_o = entry_w;

  // valid bits always form a run from the head
  `OLAR_ASSERT_IMPL(a_valid_packed, clk_i, rst_ni, 1'b1, (((valid_w >> 1) & ~valid_w) == '0))
  // every status other than a dumped entry closes its command
  `OLAR_ASSERT_IMPL(a_single_last, clk_i, rst_ni, strobe_o && (status_o != ST_ENTRY), last_o)
  // entry is zero for every status other than a dumped entry
  `OLAR_ASSERT_IMPL(a_entry_zero, clk_i, rst_ni, strobe_o && (status_o != ST_ENTRY), entry_o == '0)
  // a running dump delivers a result in the next cycle
  `OLAR_ASSERT_NEXT(a_dump_streams, clk_i, rst_ni, busy, strobe_o && (status_o == ST_ENTRY))

endmodule

// ===== tb/ordered_list_append_remove_checker.sv =====
// Checker for the ordered list: predicts result words and compares them field by field
module ordered_list_append_remove_checker
  import olar_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic [ActionW-1:0]  action_i,
  input  logic [31:0]         value_i,
  input  logic                strobe_o,
  input  logic [StatusW-1:0]  status_o,
  input  logic [31:0]         entry_o,
  input  logic                last_o,
  output int                  err_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  full_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e     status;
    logic [31:0] entry;
    logic        last;
  } list_result_t;

  logic [31:0]  list_vals[$];
  list_result_t expected_results[$];
  list_result_t want;
  int           bad_now;
  int           full_now;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    checked_o   = 0;
    full_seen_o = 0;
  end

  function automatic void expect_word(input status_e st, input logic [31:0] ent,
                                      input logic lst);
    list_result_t r;
    r.status = st;
    r.entry  = ent;
    r.last   = lst;
    expected_results.push_back(r);
  endfunction

  // Apply one command to the shadow list and queue the words it produces
  function automatic int list_apply(input action_e act, input logic [31:0] val);
    int pos;
    pos = -1;
    case (act)
      ACT_APPEND: begin
        if (list_vals.size() >= CAPACITY) begin
          expect_word(ST_FULL, '0, 1'b1);
          return 1;
        end
        list_vals.push_back(val);
        expect_word(ST_DONE, '0, 1'b1);
      end
      ACT_REMOVE: begin
        for (int i = 0; i < list_vals.size(); i++) begin
          if (pos < 0 && list_vals[i] == val) pos = i;
        end
        if (pos < 0) begin
          expect_word(ST_NOTFOUND, '0, 1'b1);
        end else begin
          list_vals.delete(pos);
          expect_word(ST_DONE, '0, 1'b1);
        end
      end
      ACT_DUMP: begin
        if (list_vals.size() == 0) begin
          expect_word(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_vals.size(); i++)
            expect_word(ST_ENTRY, list_vals[i], i == list_vals.size() - 1);
        end
      end
      default: expect_word(ST_DONE, '0, 1'b1);
    endcase
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_vals.delete();
      expected_results.delete();
      pending_o <= 0;
    end else begin
      bad_now  = 0;
      full_now = 0;
      // results of this edge belong to earlier words, so compare before predicting
      if (strobe_o) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: status %0d entry %0d last %0b",
                 status_o, $signed(entry_o), last_o);
          bad_now = 1;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            bad_now++;
          end
          if (entry_o !== want.entry) begin
            $error("entry: expected %0d, got %0d", $signed(want.entry), $signed(entry_o));
            bad_now++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            bad_now++;
          end
        end
      end
      if (start && !busy)
        full_now = list_apply(action_e'(action_i), value_i);
      err_count_o <= err_count_o + bad_now;
      checked_o   <= checked_o + (strobe_o ? 1 : 0);
      full_seen_o <= full_seen_o + full_now;
      pending_o   <= expected_results.size();
    end
  end

endmodule

// ===== tb/ordered_list_append_remove_test.sv =====
// Top of the ordered list testbench: clock, reset, command stimulus and verdict
module ordered_list_append_remove_test;
  import olar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = 32;
  localparam int NumItems   = 260;
  localparam int QuietTail  = 40;
  localparam int IdleLimit  = 1000;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               start    = 1'b0;
  logic               busy;
  logic [ActionW-1:0] action_i = '0;
  logic [31:0]        value_i  = '0;
  logic               strobe_o;
  logic [StatusW-1:0] status_o;
  logic [31:0]        entry_o;
  logic               last_o;

  int err_count;
  int pending;
  int checked;
  int full_seen;
  int idle_cycles = 0;
  int sent = 0;
  int act_sent[4] = '{0, 0, 0, 0};
  bit quiet = 1'b0;
  logic [31:0] pool[8];

  always #5 clk_i = ~clk_i;

  ordered_list_append_remove #(.CAPACITY(CAPACITY)) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .action_i (action_i),
    .value_i  (value_i),
    .strobe_o (strobe_o),
    .status_o (status_o),
    .entry_o  (entry_o),
    .last_o   (last_o)
  );

  ordered_list_append_remove_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .status_o    (status_o),
    .entry_o     (entry_o),
    .last_o      (last_o),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_seen_o (full_seen)
  );

  // Watchdog: any accepted word or result word resets the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input action_e act, input logic [31:0] val);
    start    <= 1'b1;
    action_i <= act;
    value_i  <= val;
    do @(posedge clk_i); while (busy);
    sent++;
    act_sent[act]++;
  endtask

  // Drop start for a while, with junk on the data lines
  task automatic pause_sender(input int cycles);
    start    <= 1'b0;
    action_i <= ActionW'($urandom);
    value_i  <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 5) == 0)
      pause_sender($urandom_range(1, 18));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [31:0] pick_value(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // One random stretch: grow favors appends, shrink favors removes
  task automatic run_round(input int kind, input int len);
    int roll;
    action_e act;
    for (int k = 0; k < len && sent < NumItems; k++) begin
      quiet = (sent >= NumItems - QuietTail);
      roll = $urandom_range(0, 99);
      if (roll < 3) act = ACT_NONE;
      else if (roll < 12) act = ACT_DUMP;
      else if (roll < (kind == 0 ? 80 : 35)) act = ACT_APPEND;
      else act = ACT_REMOVE;
      send_word(act, pick_value(act == ACT_REMOVE ? 85 : 60));
      maybe_idle();
    end
  endtask

  initial begin
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) pool[i] = $urandom;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list cases, extremes, duplicates, head/middle/tail removal
    send_word(ACT_DUMP,   $urandom);
    send_word(ACT_REMOVE, 32'h0000_0007);
    send_word(ACT_NONE,   32'hFFFF_FFFF);
    send_word(ACT_APPEND, 32'h8000_0000);
    send_word(ACT_APPEND, 32'h7FFF_FFFF);
    send_word(ACT_APPEND, 32'h0000_0000);
    send_word(ACT_APPEND, 32'hFFFF_FFFF);
    send_word(ACT_APPEND, 32'h0000_0000);
    send_word(ACT_DUMP,   32'h5555_AAAA);
    send_word(ACT_REMOVE, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'h8000_0000);
    send_word(ACT_REMOVE, 32'h0000_1234);
    send_word(ACT_DUMP,   32'h0000_0000);
    send_word(ACT_REMOVE, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'hFFFF_FFFF);
    send_word(ACT_REMOVE, 32'h7FFF_FFFF);
    send_word(ACT_DUMP,   32'hFFFF_FFFF);
    drain();

    // fill past capacity so appends are dropped, then dump the full list
    for (int k = 0; k < CAPACITY + 3; k++) begin
      send_word(ACT_APPEND, pick_value(50));
      maybe_idle();
    end
    send_word(ACT_DUMP, $urandom);
    maybe_idle();

    while (sent < NumItems / 2)
      run_round($urandom_range(0, 1), $urandom_range(8, 40));
    drain();
    while (sent < NumItems)
      run_round($urandom_range(0, 1), $urandom_range(8, 40));

    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d commands: %0d append, %0d remove, %0d dump, %0d no-op",
             sent, act_sent[ACT_APPEND], act_sent[ACT_REMOVE], act_sent[ACT_DUMP],
             act_sent[ACT_NONE]);
    $display("Checked %0d result words; append to a full list seen %0d times",
             checked, full_seen);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
